### src/complex_number_alu_macros.svh
// Assertion macros shared by the checker of complex_number_alu.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef COMPLEX_NUMBER_ALU_MACROS_SVH
`define COMPLEX_NUMBER_ALU_MACROS_SVH
// Same-cycle implication.
`define CNALU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cnalu assertion failed");
// Next-cycle implication.
`define CNALU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cnalu assertion failed");
`endif

### src/cnalu_pkg.sv
// Package of the complex number ALU: operation codes, compare codes and
// the control word that travels with each item. No dependencies.
package cnalu_pkg;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_MAG  = 3'd4,
    OP_CMP  = 3'd5,
    OP_RCMP = 3'd6
  } op_e;

  localparam logic [1:0] ORD_GT = 2'b01;
  localparam logic [1:0] ORD_EQ = 2'b00;
  localparam logic [1:0] ORD_LT = 2'b11;

  typedef struct packed {
    op_e        op;
    logic [1:0] ord;
    logic       dz;
    logic       neg_re;
    logic       neg_im;
    logic       ovf_re;
    logic       ovf_im;
  } ctrl_t;

endpackage

### src/cnalu_if.sv
// Valid/ready channel interfaces of the complex number ALU.
// Operand channel and result channel; no package dependency.
interface cnalu_in_if #(parameter int DW = 16);
  logic                 valid;
  logic                 ready;
  logic [2:0]           operation;
  logic signed [DW-1:0] a_real;
  logic signed [DW-1:0] a_imag;
  logic signed [DW-1:0] b_real;
  logic signed [DW-1:0] b_imag;
  modport source (output valid, operation, a_real, a_imag, b_real, b_imag, input ready);
  modport sink (input valid, operation, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cnalu_out_if #(parameter int DW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] res_real;
  logic signed [DW-1:0] res_imag;
  logic signed [1:0]    order;
  logic                 saturated;
  logic                 divide_by_zero;
  modport source (output valid, res_real, res_imag, order, saturated, divide_by_zero,
                  input ready);
  modport sink (input valid, res_real, res_imag, order, saturated, divide_by_zero,
                output ready);
endinterface

### src/cnalu_front.sv
// Front end of the complex number ALU: products, sums and divide setup in
// three register stages. Depends on cnalu_pkg.
module cnalu_front #(
  parameter int DW = 16,
  parameter int FB = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [2:0]               operation_i,
  input  logic signed [DW-1:0]     a_real_i,
  input  logic signed [DW-1:0]     a_imag_i,
  input  logic signed [DW-1:0]     b_real_i,
  input  logic signed [DW-1:0]     b_imag_i,
  output logic                     valid_o,
  output cnalu_pkg::ctrl_t         ctrl_o,
  output logic [2*DW+FB-1:0]       rem_re_o,
  output logic [2*DW+FB-1:0]       rem_im_o,
  output logic [2*DW-1:0]          div_o,
  output logic [2*DW-1:0]          sq_o
);
  localparam int PW = 2 * DW;
  localparam int NW = 2 * DW + FB;
  localparam int WW = 3 * DW + FB;

  // stage 1: operands and products
  logic                 v1_q;
  cnalu_pkg::op_e       op1_q;
  logic signed [DW-1:0] ar1_q, ai1_q, br1_q, bi1_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [PW-1:0] p_aa_q, p_ab_q, p_ba_q, p_bb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q  <= cnalu_pkg::op_e'(operation_i);
      ar1_q  <= a_real_i;
      ai1_q  <= a_imag_i;
      br1_q  <= b_real_i;
      bi1_q  <= b_imag_i;
      p_rr_q <= PW'(a_real_i) * PW'(b_real_i);
      p_ii_q <= PW'(a_imag_i) * PW'(b_imag_i);
      p_ri_q <= PW'(a_real_i) * PW'(b_imag_i);
      p_ir_q <= PW'(a_imag_i) * PW'(b_real_i);
      p_aa_q <= PW'(a_real_i) * PW'(a_real_i);
      p_ab_q <= PW'(a_imag_i) * PW'(a_imag_i);
      p_ba_q <= PW'(b_real_i) * PW'(b_real_i);
      p_bb_q <= PW'(b_imag_i) * PW'(b_imag_i);
    end
  end

  // stage 2: signed sums turned into sign and magnitude
  logic signed [PW:0] xr, xi;
  logic [PW-1:0]      mre_d, mim_d, sa_d, sb_d;

  always_comb begin
    xr = '0;
    xi = '0;
    case (op1_q)
      cnalu_pkg::OP_ADD: begin
        xr = (PW+1)'(ar1_q) + (PW+1)'(br1_q);
        xi = (PW+1)'(ai1_q) + (PW+1)'(bi1_q);
      end
      cnalu_pkg::OP_SUB: begin
        xr = (PW+1)'(ar1_q) - (PW+1)'(br1_q);
        xi = (PW+1)'(ai1_q) - (PW+1)'(bi1_q);
      end
      cnalu_pkg::OP_MUL: begin
        xr = (PW+1)'(p_rr_q) - (PW+1)'(p_ii_q);
        xi = (PW+1)'(p_ri_q) + (PW+1)'(p_ir_q);
      end
      cnalu_pkg::OP_DIV: begin
        xr = (PW+1)'(p_rr_q) + (PW+1)'(p_ii_q);
        xi = (PW+1)'(p_ir_q) - (PW+1)'(p_ri_q);
      end
      default: begin
        xr = '0;
        xi = '0;
      end
    endcase
    mre_d = PW'(xr[PW] ? -xr : xr);
    mim_d = PW'(xi[PW] ? -xi : xi);
    // product fraction bits drop toward zero
    if (op1_q == cnalu_pkg::OP_MUL) begin
      mre_d = mre_d >> FB;
      mim_d = mim_d >> FB;
    end
    sa_d = PW'(p_aa_q) + PW'(p_ab_q);
    sb_d = PW'(p_ba_q) + PW'(p_bb_q);
  end

  logic           v2_q;
  cnalu_pkg::op_e op2_q;
  logic [PW-1:0]  mre2_q, mim2_q, sa2_q, sb2_q;
  logic           nre2_q, nim2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op2_q  <= op1_q;
      mre2_q <= mre_d;
      mim2_q <= mim_d;
      nre2_q <= xr[PW];
      nim2_q <= xi[PW];
      sa2_q  <= sa_d;
      sb2_q  <= sb_d;
    end
  end

  // stage 3: scale numerators, flag quotient overflow, compare magnitudes
  logic [NW-1:0]    nre, nim;
  logic [WW-1:0]    dlim;
  cnalu_pkg::ctrl_t ctrl_d;

  always_comb begin
    nre  = NW'(mre2_q) << FB;
    nim  = NW'(mim2_q) << FB;
    dlim = WW'(sb2_q) << DW;
    ctrl_d.op     = op2_q;
    ctrl_d.neg_re = nre2_q;
    ctrl_d.neg_im = nim2_q;
    ctrl_d.dz     = (op2_q == cnalu_pkg::OP_DIV) && (sb2_q == '0);
    ctrl_d.ovf_re = WW'(nre) >= dlim;
    ctrl_d.ovf_im = WW'(nim) >= dlim;
    case (op2_q)
      cnalu_pkg::OP_CMP: begin
        ctrl_d.ord = (sa2_q > sb2_q) ? cnalu_pkg::ORD_GT :
                     (sa2_q == sb2_q) ? cnalu_pkg::ORD_EQ : cnalu_pkg::ORD_LT;
      end
      cnalu_pkg::OP_RCMP: begin
        ctrl_d.ord = (sa2_q > sb2_q) ? cnalu_pkg::ORD_LT :
                     (sa2_q == sb2_q) ? cnalu_pkg::ORD_EQ : cnalu_pkg::ORD_GT;
      end
      default: begin
        ctrl_d.ord = cnalu_pkg::ORD_EQ;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrl_o   <= ctrl_d;
      rem_re_o <= (op2_q == cnalu_pkg::OP_DIV) ? nre : NW'(mre2_q);
      rem_im_o <= (op2_q == cnalu_pkg::OP_DIV) ? nim : NW'(mim2_q);
      div_o    <= sb2_q;
      sq_o     <= sa2_q;
    end
  end

endmodule

### src/cnalu_cell.sv
// One cell of the divide/root chain: settles quotient bit K of both
// lanes and root bit K, then hands the item on. Depends on cnalu_pkg.
module cnalu_cell #(
  parameter int DW = 16,
  parameter int FB = 8,
  parameter int K  = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  cnalu_pkg::ctrl_t   ctrl_i,
  input  logic [2*DW+FB-1:0] rem_re_i,
  input  logic [2*DW+FB-1:0] rem_im_i,
  input  logic [DW-1:0]      q_re_i,
  input  logic [DW-1:0]      q_im_i,
  input  logic [2*DW-1:0]    div_i,
  input  logic [2*DW-1:0]    sq_i,
  input  logic [DW-1:0]      root_i,
  output logic               valid_o,
  output cnalu_pkg::ctrl_t   ctrl_o,
  output logic [2*DW+FB-1:0] rem_re_o,
  output logic [2*DW+FB-1:0] rem_im_o,
  output logic [DW-1:0]      q_re_o,
  output logic [DW-1:0]      q_im_o,
  output logic [2*DW-1:0]    div_o,
  output logic [2*DW-1:0]    sq_o,
  output logic [DW-1:0]      root_o
);
  localparam int PW = 2 * DW;
  localparam int NW = 2 * DW + FB;
  localparam int WW = 3 * DW + FB;
  localparam int SW = 2 * DW + 1;

  logic [WW-1:0]   dk;
  logic [SW-1:0]   trial;
  logic [NW-1:0]   rre_d, rim_d;
  logic [DW-1:0]   qre_d, qim_d, root_d;
  logic [PW-1:0]   sq_d;
  logic            is_div;

  always_comb begin
    is_div = (ctrl_i.op == cnalu_pkg::OP_DIV);
    dk     = WW'(div_i) << K;
    rre_d  = rem_re_i;
    rim_d  = rem_im_i;
    qre_d  = q_re_i;
    qim_d  = q_im_i;
    if (is_div && (WW'(rem_re_i) >= dk)) begin
      rre_d = NW'(WW'(rem_re_i) - dk);
      qre_d = q_re_i | (DW'(1) << K);
    end
    if (is_div && (WW'(rem_im_i) >= dk)) begin
      rim_d = NW'(WW'(rem_im_i) - dk);
      qim_d = q_im_i | (DW'(1) << K);
    end
    // restoring square root: try (root + 2^K)^2 against the remainder
    trial  = (SW'(root_i) << (K + 1)) + (SW'(1) << (2 * K));
    sq_d   = sq_i;
    root_d = root_i;
    if (SW'(sq_i) >= trial) begin
      sq_d   = PW'(SW'(sq_i) - trial);
      root_d = root_i | (DW'(1) << K);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrl_o   <= ctrl_i;
      rem_re_o <= rre_d;
      rem_im_o <= rim_d;
      q_re_o   <= qre_d;
      q_im_o   <= qim_d;
      div_o    <= div_i;
      sq_o     <= sq_d;
      root_o   <= root_d;
    end
  end

endmodule

### src/cnalu_back.sv
// Back end of the complex number ALU: picks the result per operation,
// saturates it and holds it in the output register. Depends on cnalu_pkg
// and cnalu_out_if.
module cnalu_back #(
  parameter int DW = 16,
  parameter int FB = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  cnalu_pkg::ctrl_t   ctrl_i,
  input  logic [2*DW+FB-1:0] rem_re_i,
  input  logic [2*DW+FB-1:0] rem_im_i,
  input  logic [DW-1:0]      q_re_i,
  input  logic [DW-1:0]      q_im_i,
  input  logic [DW-1:0]      root_i,
  output logic               en_o,
  cnalu_out_if.source        out_o
);
  localparam int NW = 2 * DW + FB;
  localparam logic [NW-1:0] MaxMag = {{(NW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic [NW-1:0] MinMag = MaxMag + NW'(1);

  // returns {saturated, value}
  function automatic logic [DW:0] clampf(input logic [NW-1:0] m, input logic neg,
                                         input logic big);
    logic [DW:0] r;
    if (!neg) begin
      if (big || (m > MaxMag)) r = {1'b1, MaxMag[DW-1:0]};
      else                     r = {1'b0, m[DW-1:0]};
    end else begin
      if (big || (m > MinMag)) r = {1'b1, MinMag[DW-1:0]};
      else                     r = {1'b0, DW'(NW'(0) - m)};
    end
    return r;
  endfunction

  logic [NW-1:0] m_re, m_im;
  logic          n_re, n_im, b_re, b_im;
  logic [DW:0]   c_re, c_im;

  always_comb begin
    m_re = '0;
    m_im = '0;
    n_re = 1'b0;
    n_im = 1'b0;
    b_re = 1'b0;
    b_im = 1'b0;
    case (ctrl_i.op)
      cnalu_pkg::OP_ADD, cnalu_pkg::OP_SUB, cnalu_pkg::OP_MUL: begin
        m_re = rem_re_i;
        m_im = rem_im_i;
        n_re = ctrl_i.neg_re;
        n_im = ctrl_i.neg_im;
      end
      cnalu_pkg::OP_DIV: begin
        // a zero divisor yields zero with no saturation
        if (!ctrl_i.dz) begin
          m_re = NW'(q_re_i);
          m_im = NW'(q_im_i);
          n_re = ctrl_i.neg_re;
          n_im = ctrl_i.neg_im;
          b_re = ctrl_i.ovf_re;
          b_im = ctrl_i.ovf_im;
        end
      end
      cnalu_pkg::OP_MAG: begin
        m_re = NW'(root_i);
      end
      default: begin
        m_re = '0;
      end
    endcase
    c_re = clampf(m_re, n_re, b_re);
    c_im = clampf(m_im, n_im, b_im);
  end

  logic valid_q;

  assign en_o        = !valid_q || out_o.ready;
  assign out_o.valid = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      out_o.res_real       <= c_re[DW-1:0];
      out_o.res_imag       <= c_im[DW-1:0];
      out_o.order          <= ctrl_i.ord;
      out_o.saturated      <= c_re[DW] | c_im[DW];
      out_o.divide_by_zero <= ctrl_i.dz;
    end
  end

endmodule

### src/complex_number_alu.sv
// Complex number ALU on signed fixed-point operands.
// Channels: in_i carries an operation code and two complex operands, out_o
// one result item per input item (real, imaginary, order, saturated,
// divide_by_zero). Both are valid/ready; an item moves when both are high.
// Structure: three front stages (products, sums, divide setup), a chain of
// DATA_WIDTH cells that each settle one quotient bit for both lanes and one
// root bit, then a saturating output register.
// Path: an accepted item passes the three front stages, the DATA_WIDTH
// cells and the output register before out_o.valid shows its result.
// Throughput: one item per cycle unless stalled; stages advance together,
// so a new item enters each cycle while earlier ones are in the chain.
// Stall: when out_o.ready is low with a result held, the whole pipeline
// holds and in_i.ready drops; nothing is lost or repeated.
// Reset: rst_ni clears all stage valid bits; the pipeline comes up empty
// and accepts items as soon as reset is released.
// Unused operation code: all result fields are zero.
// Depends on cnalu_pkg, cnalu_if, cnalu_front, cnalu_cell, cnalu_back.
module complex_number_alu #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cnalu_in_if.sink    in_i,
  cnalu_out_if.source out_o
);
  localparam int DW = DATA_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int PW = 2 * DW;
  localparam int NW = 2 * DW + FB;

  logic                 en;
  logic [DW:0]          v_c;
  cnalu_pkg::ctrl_t     ctrl_c [DW+1];
  logic [NW-1:0]        rre_c  [DW+1];
  logic [NW-1:0]        rim_c  [DW+1];
  logic [DW-1:0]        qre_c  [DW+1];
  logic [DW-1:0]        qim_c  [DW+1];
  logic [PW-1:0]        div_c  [DW+1];
  logic [PW-1:0]        sq_c   [DW+1];
  logic [DW-1:0]        root_c [DW+1];

  assign in_i.ready = en;
  assign qre_c[0]   = '0;
  assign qim_c[0]   = '0;
  assign root_c[0]  = '0;

  cnalu_front #(.DW(DW), .FB(FB)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_i.valid),
    .operation_i (in_i.operation),
    .a_real_i    (in_i.a_real),
    .a_imag_i    (in_i.a_imag),
    .b_real_i    (in_i.b_real),
    .b_imag_i    (in_i.b_imag),
    .valid_o     (v_c[0]),
    .ctrl_o      (ctrl_c[0]),
    .rem_re_o    (rre_c[0]),
    .rem_im_o    (rim_c[0]),
    .div_o       (div_c[0]),
    .sq_o        (sq_c[0])
  );

  for (genvar i = 0; i < DW; i++) begin : g_cell
    cnalu_cell #(.DW(DW), .FB(FB), .K(DW - 1 - i)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .valid_i  (v_c[i]),
      .ctrl_i   (ctrl_c[i]),
      .rem_re_i (rre_c[i]),
      .rem_im_i (rim_c[i]),
      .q_re_i   (qre_c[i]),
      .q_im_i   (qim_c[i]),
      .div_i    (div_c[i]),
      .sq_i     (sq_c[i]),
      .root_i   (root_c[i]),
      .valid_o  (v_c[i+1]),
      .ctrl_o   (ctrl_c[i+1]),
      .rem_re_o (rre_c[i+1]),
      .rem_im_o (rim_c[i+1]),
      .q_re_o   (qre_c[i+1]),
      .q_im_o   (qim_c[i+1]),
      .div_o    (div_c[i+1]),
      .sq_o     (sq_c[i+1]),
      .root_o   (root_c[i+1])
    );
  end

  cnalu_back #(.DW(DW), .FB(FB)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (v_c[DW]),
    .ctrl_i   (ctrl_c[DW]),
    .rem_re_i (rre_c[DW]),
    .rem_im_i (rim_c[DW]),
    .q_re_i   (qre_c[DW]),
    .q_im_i   (qim_c[DW]),
    .root_i   (root_c[DW]),
    .en_o     (en),
    .out_o    (out_o)
  );

endmodule

### src/cnalu_checker.sv
// Port-level checker of complex_number_alu, bound to the top level.
// Depends on complex_number_alu_macros.svh.
`include "complex_number_alu_macros.svh"

module cnalu_checker #(
  parameter int DW = 16
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [DW-1:0] res_real,
  input logic signed [DW-1:0] res_imag,
  input logic signed [1:0]    order,
  input logic                 saturated,
  input logic                 divide_by_zero
);
  localparam logic signed [DW-1:0] MaxVal = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MinVal = {1'b1, {(DW-1){1'b0}}};

  `CNALU_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `CNALU_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(res_real) && $stable(res_imag))
  `CNALU_ASSERT_IMP(a_dz_zero, out_valid && divide_by_zero, res_real == 0 && res_imag == 0 && !saturated && order == 0)
  `CNALU_ASSERT_IMP(a_cmp_zero, out_valid && order != 0, res_real == 0 && res_imag == 0 && !saturated && !divide_by_zero)
  `CNALU_ASSERT_IMP(a_sat_rail, out_valid && saturated, res_real == MaxVal || res_real == MinVal || res_imag == MaxVal || res_imag == MinVal)

endmodule

bind complex_number_alu cnalu_checker #(.DW(DATA_WIDTH)) u_cnalu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .res_real       (out_o.res_real),
  .res_imag       (out_o.res_imag),
  .order          (out_o.order),
  .saturated      (out_o.saturated),
  .divide_by_zero (out_o.divide_by_zero)
);
